### design/cau_pkg.sv
package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUOT_BITS     = 33;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_ADDSUB = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2,
        K_DIVZ   = 2'd3
    } t_kind;

    typedef struct packed {
        logic        [1:0]  req_type;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_req;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               overflow;
        logic               div_zero;
    } t_res;

    // classified item as it waits in the queue
    typedef struct packed {
        t_kind              kind;
        logic signed [32:0] sum_re;
        logic signed [32:0] sum_im;
        logic signed [63:0] p_rr;
        logic signed [63:0] p_ii;
        logic signed [63:0] p_ri;
        logic signed [63:0] p_ir;
        logic        [63:0] den;
    } t_entry;

    // one stage of the back pipeline
    typedef struct packed {
        t_kind                  kind;
        logic signed [31:0]     re;
        logic signed [31:0]     im;
        logic                   ov;
        logic                   neg_re;
        logic                   neg_im;
        logic                   big_re;
        logic                   big_im;
        logic [63:0]            rem_re;
        logic [63:0]            rem_im;
        logic [QUOT_BITS-1:0]   q_re;
        logic [QUOT_BITS-1:0]   q_im;
        logic [QUOT_BITS-1:0]   n_re;
        logic [QUOT_BITS-1:0]   n_im;
        logic [63:0]            den;
    } t_bst;

endpackage

### design/complex_arith_unit.sv
// Complex add/subtract/multiply/divide on signed fixed point operands.
// Throughput: one item per cycle unless the output stalls; the divider is a 33-stage restoring pipeline,
// one quotient bit per stage, and every operation travels through it in order.
// Reset (synchronous, active low) empties the front register, queue and pipeline.
module complex_arith_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cau_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output cau_pkg::t_res o_res
);

    // front -> queue
    logic            push;
    logic            full;
    cau_pkg::t_entry f_ent;

    // queue -> back
    logic            nempty;
    logic            pop;
    cau_pkg::t_entry q_ent;

    // Front: take the transfer, form the products, squared magnitude and
    // sums, and tag the item; a zero divisor is spotted here.
    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_push  (push),
        .i_full  (full),
        .o_ent   (f_ent)
    );

    // Short queue: hold classified items so the front keeps taking
    // transfers while the back is stalled.
    cau_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_ent    (f_ent),
        .o_full   (full),
        .o_nempty (nempty),
        .i_pop    (pop),
        .o_ent    (q_ent)
    );

    // Back: saturate, round and divide; advance only while the output
    // register is free or being drained.
    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (nempty),
        .o_pop   (pop),
        .i_ent   (q_ent),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

endmodule

### design/cau_front.sv
module cau_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cau_pkg::t_req i_req,
    output logic          o_push,
    input  logic          i_full,
    output cau_pkg::t_entry o_ent
);

    logic             r_valid;
    cau_pkg::t_entry  r_ent;
    cau_pkg::t_entry  n_ent;
    logic             accept;

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_ent   = r_ent;

    always_comb begin
        logic signed [63:0] p_bb;
        logic signed [63:0] p_jj;
        p_bb = i_req.b_re * i_req.b_re;
        p_jj = i_req.b_im * i_req.b_im;
        n_ent.p_rr = i_req.a_re * i_req.b_re;
        n_ent.p_ii = i_req.a_im * i_req.b_im;
        n_ent.p_ri = i_req.a_re * i_req.b_im;
        n_ent.p_ir = i_req.a_im * i_req.b_re;
        n_ent.den  = 64'(p_bb) + 64'(p_jj);
        n_ent.sum_re = 33'(i_req.a_re) + 33'(i_req.b_re);
        n_ent.sum_im = 33'(i_req.a_im) + 33'(i_req.b_im);
        case (cau_pkg::t_op'(i_req.req_type))
            cau_pkg::OP_ADD: n_ent.kind = cau_pkg::K_ADDSUB;
            cau_pkg::OP_SUB: begin
                n_ent.kind   = cau_pkg::K_ADDSUB;
                n_ent.sum_re = 33'(i_req.a_re) - 33'(i_req.b_re);
                n_ent.sum_im = 33'(i_req.a_im) - 33'(i_req.b_im);
            end
            cau_pkg::OP_MUL: n_ent.kind = cau_pkg::K_MUL;
            cau_pkg::OP_DIV: begin
                // zero divisor is tagged here so its result skips the division
                if (i_req.b_re == 32'sd0 && i_req.b_im == 32'sd0) begin
                    n_ent.kind = cau_pkg::K_DIVZ;
                end else begin
                    n_ent.kind = cau_pkg::K_DIV;
                end
            end
            default: n_ent.kind = cau_pkg::K_ADDSUB;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent <= n_ent;
        end
    end

endmodule

### design/cau_queue.sv
module cau_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cau_pkg::t_entry i_ent,
    output logic            o_full,
    output logic            o_nempty,
    input  logic            i_pop,
    output cau_pkg::t_entry o_ent
);

    localparam int AW = $clog2(cau_pkg::QUEUE_DEPTH);

    cau_pkg::t_entry r_mem [cau_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [AW:0]     r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full   = (r_cnt == (AW+1)'(cau_pkg::QUEUE_DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_nempty;
    assign o_ent    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

endmodule

### design/cau_back.sv
module cau_back #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_pop,
    input  cau_pkg::t_entry i_ent,
    output logic            o_valid,
    input  logic            i_ready,
    output cau_pkg::t_res   o_res
);

    localparam int QB  = cau_pkg::QUOT_BITS;
    localparam int NST = QB + 1;
    localparam int NW  = 64 + FRAC_BITS;

    logic            r_v  [NST];
    cau_pkg::t_bst   r_st [NST];
    cau_pkg::t_bst   n_st [NST];
    logic            r_out_v;
    cau_pkg::t_res   r_out;
    cau_pkg::t_res   n_out;
    logic            en;

    // whole pipeline advances unless the output is held
    assign en      = !r_out_v || i_ready;
    assign o_pop   = i_valid && en;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

    function automatic logic signed [31:0] sat_val(input logic signed [65:0] v,
                                                   output logic ov);
        ov = 1'b0;
        if (v > 66'sh7FFFFFFF) begin
            ov = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -66'sh80000000) begin
            ov = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // entry stage: saturate add/sub, round and saturate multiply, prepare divide
    always_comb begin
        logic signed [65:0] half;
        logic signed [65:0] t_re;
        logic signed [65:0] t_im;
        logic signed [64:0] num_re;
        logic signed [64:0] num_im;
        logic [63:0]        mag_re;
        logic [63:0]        mag_im;
        logic [NW-1:0]      nf_re;
        logic [NW-1:0]      nf_im;
        logic               ov_re;
        logic               ov_im;
        half = 66'sd1 <<< (FRAC_BITS - 1);
        t_re = '0;
        t_im = '0;
        n_st[0]      = '0;
        n_st[0].kind = i_ent.kind;
        n_st[0].den  = i_ent.den;
        ov_re = 1'b0;
        ov_im = 1'b0;
        case (i_ent.kind)
            cau_pkg::K_ADDSUB: begin
                n_st[0].re = sat_val(66'(i_ent.sum_re), ov_re);
                n_st[0].im = sat_val(66'(i_ent.sum_im), ov_im);
            end
            cau_pkg::K_MUL: begin
                t_re = (66'(i_ent.p_rr) - 66'(i_ent.p_ii) + half) >>> FRAC_BITS;
                t_im = (66'(i_ent.p_ri) + 66'(i_ent.p_ir) + half) >>> FRAC_BITS;
                n_st[0].re = sat_val(t_re, ov_re);
                n_st[0].im = sat_val(t_im, ov_im);
            end
            default: begin
            end
        endcase
        n_st[0].ov = ov_re | ov_im;
        num_re = 65'(i_ent.p_rr) + 65'(i_ent.p_ii);
        num_im = 65'(i_ent.p_ir) - 65'(i_ent.p_ri);
        n_st[0].neg_re = num_re[64];
        n_st[0].neg_im = num_im[64];
        mag_re = num_re[64] ? 64'(-num_re) : num_re[63:0];
        mag_im = num_im[64] ? 64'(-num_im) : num_im[63:0];
        nf_re  = {mag_re, {FRAC_BITS{1'b0}}};
        nf_im  = {mag_im, {FRAC_BITS{1'b0}}};
        n_st[0].rem_re = 64'(nf_re[NW-1:QB]);
        n_st[0].rem_im = 64'(nf_im[NW-1:QB]);
        n_st[0].n_re   = nf_re[QB-1:0];
        n_st[0].n_im   = nf_im[QB-1:0];
        n_st[0].big_re = n_st[0].rem_re >= i_ent.den;
        n_st[0].big_im = n_st[0].rem_im >= i_ent.den;
    end

    // one quotient bit per stage for each part
    for (genvar j = 1; j < NST; j++) begin : g_div
        always_comb begin
            logic [64:0] t_re;
            logic [64:0] t_im;
            logic [64:0] d;
            d    = {1'b0, r_st[j-1].den};
            t_re = {r_st[j-1].rem_re, r_st[j-1].n_re[QB-j]};
            t_im = {r_st[j-1].rem_im, r_st[j-1].n_im[QB-j]};
            n_st[j]      = r_st[j-1];
            n_st[j].q_re = {r_st[j-1].q_re[QB-2:0], 1'b0};
            n_st[j].q_im = {r_st[j-1].q_im[QB-2:0], 1'b0};
            if (t_re >= d) begin
                t_re = t_re - d;
                n_st[j].q_re[0] = 1'b1;
            end
            if (t_im >= d) begin
                t_im = t_im - d;
                n_st[j].q_im[0] = 1'b1;
            end
            n_st[j].rem_re = t_re[63:0];
            n_st[j].rem_im = t_im[63:0];
        end
    end

    function automatic logic [31:0] div_fin(input logic neg, input logic big,
                                            input logic [QB-1:0] q,
                                            input logic [63:0] rem,
                                            input logic [63:0] den,
                                            output logic ov);
        logic [QB:0] qr;
        logic [QB:0] lim;
        lim = neg ? (QB+1)'(34'h80000000) : (QB+1)'(34'h7FFFFFFF);
        qr  = {1'b0, q} + (QB+1)'(rem >= den - rem);
        ov  = 1'b0;
        if (big || qr > lim) begin
            ov = 1'b1;
            qr = lim;
        end
        return neg ? (~qr[31:0] + 32'd1) : qr[31:0];
    endfunction

    always_comb begin
        logic ov_re;
        logic ov_im;
        ov_re = 1'b0;
        ov_im = 1'b0;
        n_out = '0;
        case (r_st[NST-1].kind)
            cau_pkg::K_DIV: begin
                n_out.res_re = div_fin(r_st[NST-1].neg_re, r_st[NST-1].big_re,
                    r_st[NST-1].q_re, r_st[NST-1].rem_re, r_st[NST-1].den, ov_re);
                n_out.res_im = div_fin(r_st[NST-1].neg_im, r_st[NST-1].big_im,
                    r_st[NST-1].q_im, r_st[NST-1].rem_im, r_st[NST-1].den, ov_im);
                n_out.overflow = ov_re | ov_im;
            end
            cau_pkg::K_DIVZ: n_out.div_zero = 1'b1;
            default: begin
                n_out.res_re   = r_st[NST-1].re;
                n_out.res_im   = r_st[NST-1].im;
                n_out.overflow = r_st[NST-1].ov;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_out_v <= r_v[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
            r_out <= n_out;
        end
    end

endmodule

### design/cau_checker.sv
module cau_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input cau_pkg::t_req i_req,
    input logic          o_valid,
    input logic          i_ready,
    input cau_pkg::t_res o_res
);

    // hold an offered item until it is transferred
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_req))
        else $error("offered item changed before transfer");

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.div_zero |->
            o_res.res_re == 32'sd0 && o_res.res_im == 32'sd0 && !o_res.overflow)
        else $error("zero divisor result not clean");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.overflow |->
            o_res.res_re == 32'sh7FFFFFFF || o_res.res_re == 32'sh80000000 ||
            o_res.res_im == 32'sh7FFFFFFF || o_res.res_im == 32'sh80000000)
        else $error("overflow without saturated part");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_req   (i_req),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_res   (o_res)
);
